FILE: hdl/sm3_pkg.sv
package sm3_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [7:0] words8_t;

    localparam word_t T_LOW   = 32'h79cc4519;
    localparam word_t T_HIGH  = 32'h7a879d8a;
    // T_HIGH rotated left by 16, the constant that round 16 needs
    localparam word_t T_HIGH_R16 = {T_HIGH[15:0], T_HIGH[31:16]};
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam word_t PAD_WORD = {PAD_BYTE, 24'h000000};

    localparam words8_t SM3_IV = '{
        32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
        32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f
    };

    localparam int unsigned TOTAL_W   = 61;
    localparam int unsigned BLK_WORDS = 16;
    localparam int unsigned ROUNDS    = 64;

    // control from the sequencer to the message schedule
    typedef struct packed {
        logic  put;     // shift a message word in
        logic  expand;  // shift in the next expanded word
        word_t word;
    } sched_ctrl_t;

    // control from the sequencer to the round unit
    typedef struct packed {
        logic  load;    // take the chaining value
        logic  step;    // run one round
        logic  first16; // rounds 0-15
        word_t tj;      // round constant, already rotated
    } round_ctrl_t;

    // rotate left, n a constant in 1..31
    function automatic word_t rotl(word_t x, int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic word_t perm0(word_t x);
        return x ^ rotl(x, 9) ^ rotl(x, 17);
    endfunction

    function automatic word_t perm1(word_t x);
        return x ^ rotl(x, 15) ^ rotl(x, 23);
    endfunction

endpackage

FILE: hdl/sm3_hash_engine.sv
// SM3 hash engine, 256-bit digest.
//
// Input channel (s_*): one item carries up to four message bytes, first byte
// in s_tdata[31:24], with the count of valid bytes in s_tdata[34:32]. Every
// item but the last of a message holds four bytes; a short non-final item is
// dropped. s_tlast marks the final item, which may hold zero to four bytes.
// Output channel (m_*): after the final item the digest leaves as eight
// items, most significant word first, m_tuser giving the word position and
// m_tlast set on the eighth.
//
// Flow: a message word is taken whenever s_tready is high. Every sixteenth
// word starts a compression of 64 rounds, one round per cycle through the
// single round unit, during which s_tready is low. After the final item the
// padding words go in at one per cycle, save while a compression runs, and
// one or two compressions run in all, then come the eight digest items.
// While the receiver stalls the current digest item holds and nothing else is
// taken. Reset (aresetn low, synchronous) loads the initial value, clears the
// byte count and leaves the block ready for a new message.
module sm3_hash_engine
    import sm3_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] data_word, [34:32] byte_count
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);

    typedef enum logic [1:0] {ST_IDLE, ST_PAD, ST_COMP, ST_OUT} state_t;
    // padding progress: none, 0x80 word due, zero fill then high length, low length due, done
    typedef enum logic [2:0] {PH_NONE, PH_MARK, PH_ZERO, PH_LO, PH_DONE} phase_t;

    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [3:0]         widx_reg, widx_next;      // word slot in the block
    logic [TOTAL_W-1:0] total_reg, total_next;    // bytes of the message
    logic [5:0]         round_reg, round_next;
    word_t              tj_reg, tj_next;
    words8_t            chain_reg, chain_next;
    logic [2:0]         oidx_reg, oidx_next;

    sched_ctrl_t sched_ctrl;
    round_ctrl_t round_ctrl;
    word_t       w_cur, w_ahead;
    words8_t     rnd_new;

    word_t       data_in;
    logic [2:0]  nbytes;
    logic        put_en;
    word_t       put_word;
    word_t       first_word;
    logic        wrap;
    logic        in_acc;
    logic        out_acc;

    assign data_in = s_tdata[31:0];
    assign nbytes  = (s_tdata[34:32] > 3'd4) ? 3'd4 : s_tdata[34:32];
    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // final word with the 0x80 byte merged below the valid bytes when fewer than four
    always_comb begin
        case (nbytes)
            3'd0:    first_word = PAD_WORD;
            3'd1:    first_word = {data_in[31:24], PAD_BYTE, 16'h0000};
            3'd2:    first_word = {data_in[31:16], PAD_BYTE, 8'h00};
            3'd3:    first_word = {data_in[31:8], PAD_BYTE};
            default: first_word = data_in;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        widx_next  = widx_reg;
        total_next = total_reg;
        round_next = round_reg;
        tj_next    = tj_reg;
        chain_next = chain_reg;
        oidx_next  = oidx_reg;
        put_en     = 1'b0;
        put_word   = '0;

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_tlast) begin
                        total_next = total_reg + TOTAL_W'(nbytes);
                        put_en     = 1'b1;
                        put_word   = first_word;
                        phase_next = (nbytes == 3'd4) ? PH_MARK : PH_ZERO;
                        state_next = ST_PAD;
                    end else if (nbytes == 3'd4) begin
                        total_next = total_reg + TOTAL_W'(4);
                        put_en     = 1'b1;
                        put_word   = data_in;
                    end
                end
            end
            ST_PAD: begin
                put_en = 1'b1;
                case (phase_reg)
                    PH_MARK: begin
                        put_word   = PAD_WORD;
                        phase_next = PH_ZERO;
                    end
                    PH_ZERO: begin
                        // length in bits is total * 8; high word at slot 14
                        if (widx_reg == 4'd14) begin
                            put_word   = total_reg[TOTAL_W-1:29];
                            phase_next = PH_LO;
                        end else begin
                            put_word = '0;
                        end
                    end
                    PH_LO: begin
                        put_word   = {total_reg[28:0], 3'b000};
                        phase_next = PH_DONE;
                    end
                    default: begin
                        put_en = 1'b0;
                    end
                endcase
            end
            ST_COMP: begin
                round_next = round_reg + 6'd1;
                tj_next    = (round_reg == 6'd15) ? T_HIGH_R16 : rotl(tj_reg, 1);
                if (round_reg == 6'(ROUNDS - 1)) begin
                    for (int i = 0; i < 8; i++) begin
                        chain_next[i] = chain_reg[i] ^ rnd_new[i];
                    end
                    if (phase_reg == PH_DONE) begin
                        state_next = ST_OUT;
                    end else if (phase_reg == PH_NONE) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_OUT: begin
                if (out_acc) begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7) begin
                        chain_next = SM3_IV;
                        total_next = '0;
                        phase_next = PH_NONE;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // a full block starts the compression
        wrap = put_en && (widx_reg == 4'd15);
        if (put_en) begin
            widx_next = widx_reg + 4'd1;
        end
        if (wrap) begin
            state_next = ST_COMP;
            round_next = '0;
            tj_next    = T_LOW;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_NONE;
            widx_reg  <= '0;
            total_reg <= '0;
            round_reg <= '0;
            tj_reg    <= T_LOW;
            chain_reg <= SM3_IV;
            oidx_reg  <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            widx_reg  <= widx_next;
            total_reg <= total_next;
            round_reg <= round_next;
            tj_reg    <= tj_next;
            chain_reg <= chain_next;
            oidx_reg  <= oidx_next;
        end
    end

    assign sched_ctrl.put    = put_en;
    assign sched_ctrl.expand = (state_reg == ST_COMP);
    assign sched_ctrl.word   = put_word;

    assign round_ctrl.load    = wrap;
    assign round_ctrl.step    = (state_reg == ST_COMP);
    assign round_ctrl.first16 = (round_reg[5:4] == 2'b00);
    assign round_ctrl.tj      = tj_reg;

    sm3_msg_sched u_sched (
        .aclk    (aclk),
        .ctrl    (sched_ctrl),
        .w_cur   (w_cur),
        .w_ahead (w_ahead)
    );

    sm3_round u_round (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (round_ctrl),
        .chain   (chain_reg),
        .w_cur   (w_cur),
        .w_ahead (w_ahead),
        .rnd_new (rnd_new)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = chain_reg[oidx_reg];
    assign m_tuser  = oidx_reg;
    assign m_tlast  = (oidx_reg == 3'd7);

endmodule

FILE: hdl/sm3_msg_sched.sv
module sm3_msg_sched
    import sm3_pkg::*;
(
    input  logic        aclk,
    input  sched_ctrl_t ctrl,
    output word_t       w_cur,   // W[j]
    output word_t       w_ahead  // W[j+4]
);

    // sixteen-word window, oldest word at index 0
    word_t win_reg [BLK_WORDS];
    word_t w_new;

    assign w_new = perm1(win_reg[0] ^ win_reg[7] ^ rotl(win_reg[13], 15))
                   ^ rotl(win_reg[3], 7) ^ win_reg[10];

    always_ff @(posedge aclk) begin
        if (ctrl.put || ctrl.expand) begin
            for (int i = 0; i < BLK_WORDS - 1; i++) begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[BLK_WORDS - 1] <= ctrl.put ? ctrl.word : w_new;
        end
    end

    assign w_cur   = win_reg[0];
    assign w_ahead = win_reg[4];

endmodule

FILE: hdl/sm3_round.sv
module sm3_round
    import sm3_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  round_ctrl_t ctrl,
    input  words8_t     chain,
    input  word_t       w_cur,
    input  word_t       w_ahead,
    output words8_t     rnd_new   // A..H after this round
);

    words8_t r_reg;
    words8_t r_next;
    word_t   a12, ss1, ss2, ff, gg, tt1, tt2;

    always_comb begin
        a12 = rotl(r_reg[0], 12);
        ss1 = rotl(a12 + r_reg[4] + ctrl.tj, 7);
        ss2 = ss1 ^ a12;
        if (ctrl.first16) begin
            ff = r_reg[0] ^ r_reg[1] ^ r_reg[2];
            gg = r_reg[4] ^ r_reg[5] ^ r_reg[6];
        end else begin
            ff = (r_reg[0] & r_reg[1]) | (r_reg[0] & r_reg[2]) | (r_reg[1] & r_reg[2]);
            gg = (r_reg[4] & r_reg[5]) | (~r_reg[4] & r_reg[6]);
        end
        tt1 = ff + r_reg[3] + ss2 + (w_cur ^ w_ahead);
        tt2 = gg + r_reg[7] + ss1 + w_cur;

        rnd_new[0] = tt1;
        rnd_new[1] = r_reg[0];
        rnd_new[2] = rotl(r_reg[1], 9);
        rnd_new[3] = r_reg[2];
        rnd_new[4] = perm0(tt2);
        rnd_new[5] = r_reg[4];
        rnd_new[6] = rotl(r_reg[5], 19);
        rnd_new[7] = r_reg[6];

        if (ctrl.load) begin
            r_next = chain;
        end else if (ctrl.step) begin
            r_next = rnd_new;
        end else begin
            r_next = r_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_reg <= '0;
        end else begin
            r_reg <= r_next;
        end
    end

endmodule

FILE: hdl/sm3_checker.sv
module sm3_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // no new item is taken while a digest is going out
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while digest valid");

    // digest words leave in order
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser == $past(m_tuser) + 3'd1)
        else $error("digest word out of order");

    // last word carries the top index
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == 3'd7)))
        else $error("last mark on wrong word");

    // after the eighth word the block is ready again
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
        else $error("digest not closed");

    // a stalled digest word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled digest word changed");

endmodule

bind sm3_hash_engine sm3_checker u_sm3_checker (.*);
